// ===== rtl/core/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and helpers for the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int SqrtSteps = 26;
  localparam int DivSteps  = 27;

  localparam logic signed [17:0] QMAX = 18'sd131071;
  localparam logic signed [17:0] QMIN = -18'sd131072;
  localparam logic signed [20:0] ONE_Q16 = 21'sd65536;

  // component slots
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;
  localparam logic [1:0] COMP_W = 2'd3;

  typedef struct packed {
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      pos_z;
    logic [3:0][18:0] mag;
    logic [3:0]       neg;
    logic [1:0]       hr;
    logic             degen;
    logic [25:0]      root;
  } side_t;

  // magnitude of a signed numerator
  function automatic logic [18:0] abs19(input logic signed [19:0] d);
    logic [19:0] n;
    n = -d;
    return d[19] ? n[18:0] : d[18:0];
  endfunction

endpackage

// ===== rtl/core/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider: (mag * 2^23 + root / 2) / root, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module rmq_div
  import rmq_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [18:0] mag,
  input  logic [25:0] root,
  output logic [26:0] q
);

  logic [25:0] rem_r  [0:DivSteps];
  logic [26:0] op_r   [0:DivSteps];
  logic [25:0] dvs_r  [0:DivSteps];
  logic [26:0] quo_r  [0:DivSteps];
  logic [42:0] num_nxt;

  // numerator with rounding bias; upper bits are always below the divisor
  assign num_nxt = {1'b0, mag, 23'd0} + {18'd0, root[25:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {10'd0, num_nxt[42:27]};
      op_r[0]  <= num_nxt[26:0];
      dvs_r[0] <= root;
      quo_r[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [26:0] sh;
    logic [26:0] diff;
    logic        ge;
    assign sh   = {rem_r[k-1], op_r[k-1][26]};
    assign diff = sh - {1'b0, dvs_r[k-1]};
    assign ge   = sh >= {1'b0, dvs_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[25:0] : sh[25:0];
        op_r[k]  <= {op_r[k-1][25:0], 1'b0};
        dvs_r[k] <= dvs_r[k-1];
        quo_r[k] <= {quo_r[k-1][25:0], ge};
      end
    end
  end

  assign q = quo_r[DivSteps];

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Throughput: one transaction per cycle while the output is not stalled; set by the 26-step square root and
// the 27-step dividers, each step a pipeline stage of its own.
// A stall at the output while a result is held freezes the whole pipeline; nothing is lost.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x4 rigid transform into a saturated Q2.16 unit quaternion,
// passing the translation through unchanged.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_r00,
  input  logic signed [17:0] in_r01,
  input  logic signed [17:0] in_r02,
  input  logic signed [17:0] in_r10,
  input  logic signed [17:0] in_r11,
  input  logic signed [17:0] in_r12,
  input  logic signed [17:0] in_r20,
  input  logic signed [17:0] in_r21,
  input  logic signed [17:0] in_r22,
  input  logic signed [31:0] in_tx_in,
  input  logic signed [31:0] in_ty_in,
  input  logic signed [31:0] in_tz_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [17:0] out_quat_x,
  output logic signed [17:0] out_quat_y,
  output logic signed [17:0] out_quat_z,
  output logic signed [17:0] out_quat_w,
  output logic               out_degenerate
);

  localparam int RootStage = SqrtSteps + 1;
  localparam int LastStage = SqrtSteps + DivSteps + 1;

  logic        en;
  logic        vld_r  [0:LastStage];
  side_t       side_r [0:LastStage];
  logic [18:0] a_r;
  side_t       side_nxt;
  side_t       side_root;
  logic [18:0] a_nxt;

  logic [26:0] sq_rem_r  [0:SqrtSteps-1];
  logic [25:0] sq_root_r [0:SqrtSteps-1];
  logic [19:0] sq_op_r   [0:SqrtSteps-1];

  logic [26:0] quo [4];

  logic               out_valid_r;
  logic signed [31:0] out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [17:0] out_q_r   [4];
  logic signed [17:0] out_q_nxt [4];
  logic               out_degen_r;

  // pipeline advances unless a finished result is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // front stage: trace, branch choice, root argument and numerators
  always_comb begin
    logic signed [19:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [19:0] trace;
    logic signed [19:0] d_w21, d_w02, d_w10, d_s01, d_s02, d_s12;
    logic signed [19:0] dx, dy, dz, dw;
    logic signed [20:0] a_w;
    logic               tpos, sel0, sel1;
    m00 = 20'(in_r00); m01 = 20'(in_r01); m02 = 20'(in_r02);
    m10 = 20'(in_r10); m11 = 20'(in_r11); m12 = 20'(in_r12);
    m20 = 20'(in_r20); m21 = 20'(in_r21); m22 = 20'(in_r22);
    trace = m00 + m11 + m22;
    tpos  = !trace[19] && (trace != 20'sd0);
    sel0  = (m00 > m11) && (m00 > m22);
    sel1  = !sel0 && (m11 > m22);
    d_w21 = m21 - m12;
    d_w02 = m02 - m20;
    d_w10 = m10 - m01;
    d_s01 = m01 + m10;
    d_s02 = m02 + m20;
    d_s12 = m12 + m21;
    dx = d_w21; dy = d_w02; dz = d_w10; dw = '0;
    side_nxt.hr = COMP_W;
    a_w = 21'(trace) + ONE_Q16;
    if (!tpos) begin
      if (sel0) begin
        side_nxt.hr = COMP_X;
        a_w = ONE_Q16 + 21'(m00) - 21'(m11) - 21'(m22);
        dw = d_w21; dx = '0; dy = d_s01; dz = d_s02;
      end else if (sel1) begin
        side_nxt.hr = COMP_Y;
        a_w = ONE_Q16 + 21'(m11) - 21'(m00) - 21'(m22);
        dw = d_w02; dx = d_s01; dy = '0; dz = d_s12;
      end else begin
        side_nxt.hr = COMP_Z;
        a_w = ONE_Q16 + 21'(m22) - 21'(m00) - 21'(m11);
        dw = d_w10; dx = d_s02; dy = d_s12; dz = '0;
      end
    end
    side_nxt.degen = !tpos && (a_w[20] || (a_w == 21'sd0));
    a_nxt = side_nxt.degen ? 19'd1 : a_w[18:0];
    side_nxt.mag[COMP_X] = abs19(dx);
    side_nxt.mag[COMP_Y] = abs19(dy);
    side_nxt.mag[COMP_Z] = abs19(dz);
    side_nxt.mag[COMP_W] = abs19(dw);
    side_nxt.neg = {dw[19], dz[19], dy[19], dx[19]};
    side_nxt.pos_x = in_tx_in;
    side_nxt.pos_y = in_ty_in;
    side_nxt.pos_z = in_tz_in;
    side_nxt.root  = '0;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LastStage; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= LastStage; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[LastStage];
    end
  end

  // finished root joins the sideband
  always_comb begin
    side_root      = side_r[RootStage-1];
    side_root.root = sq_root_r[SqrtSteps-1];
  end

  // sideband data line
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      a_r       <= a_nxt;
      for (int i = 1; i <= LastStage; i++) begin
        if (i == RootStage) side_r[i] <= side_root;
        else side_r[i] <= side_r[i-1];
      end
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [26:0] rem_p;
    logic [25:0] root_p;
    logic [19:0] op_p;
    logic [28:0] rem_sh, trial, diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign op_p   = {1'b0, a_r};
    end else begin : g_next
      assign rem_p  = sq_rem_r[k-1];
      assign root_p = sq_root_r[k-1];
      assign op_p   = sq_op_r[k-1];
    end
    assign rem_sh = {rem_p, op_p[19:18]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= ge ? diff[26:0] : rem_sh[26:0];
        sq_root_r[k] <= {root_p[24:0], ge};
        sq_op_r[k]   <= {op_p[17:0], 2'b00};
      end
    end
  end

  // one divider per quaternion component
  for (genvar c = 0; c < 4; c++) begin : g_div
    rmq_div u_div (
      .clk  (clk),
      .en   (en),
      .mag  (side_r[SqrtSteps].mag[c]),
      .root (sq_root_r[SqrtSteps-1]),
      .q    (quo[c])
    );
  end

  // sign, half root, saturation and degenerate zeroing
  always_comb begin
    logic [26:0] hr_sum;
    logic [17:0] hr_val;
    side_t       s;
    s      = side_r[LastStage];
    hr_sum = {1'b0, s.root} + 27'd256;
    hr_val = (hr_sum[26:9] > 18'(QMAX)) ? 18'(QMAX) : hr_sum[26:9];
    for (int c = 0; c < 4; c++) begin
      if (s.degen) begin
        out_q_nxt[c] = '0;
      end else if (s.hr == 2'(c)) begin
        out_q_nxt[c] = hr_val;
      end else if (s.neg[c]) begin
        out_q_nxt[c] = (quo[c] > 27'd131072) ? QMIN : 18'(-quo[c]);
      end else begin
        out_q_nxt[c] = (quo[c] > 27'd131071) ? QMAX : quo[c][17:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x_r <= side_r[LastStage].pos_x;
      out_pos_y_r <= side_r[LastStage].pos_y;
      out_pos_z_r <= side_r[LastStage].pos_z;
      out_degen_r <= side_r[LastStage].degen;
      for (int c = 0; c < 4; c++) out_q_r[c] <= out_q_nxt[c];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_pos_z      = out_pos_z_r;
  assign out_quat_x     = out_q_r[COMP_X];
  assign out_quat_y     = out_q_r[COMP_Y];
  assign out_quat_z     = out_q_r[COMP_Z];
  assign out_quat_w     = out_q_r[COMP_W];
  assign out_degenerate = out_degen_r;

  // a degenerate transaction carries a zero quaternion
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_quat_x == 18'sd0 && out_quat_y == 18'sd0 &&
      out_quat_z == 18'sd0 && out_quat_w == 18'sd0)
    else $error("degenerate result with nonzero quaternion");

  // root argument is at least one, so the root is at least 2^16
  a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[RootStage] |-> side_r[RootStage].root >= 26'd65536)
    else $error("square root below lower bound");

  // a held result freezes the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r[LastStage]) && out_valid)
    else $error("pipeline moved while output stalled");

endmodule

// ===== sim/rotation_matrix_to_quaternion_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives 3x4 transforms through the quaternion converter with bursty input
// and a patterned output stall, predicts each quaternion in exact fixed point
// and compares every result field in arrival order.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;

  localparam int NumRandom = 1500;
  localparam int DrainCycles = 120;

  typedef struct {
    logic signed [17:0] r [9];
    logic signed [31:0] t [3];
  } xform_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [17:0] qx, qy, qz, qw;
    logic               degen;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [17:0] in_r [9];
  logic signed [31:0] in_t [3];
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [17:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  logic out_degenerate;

  xform_t pending_xforms[$];
  pose_t  expected_poses[$];
  int     mismatches = 0;
  bit     stimulus_done = 1'b0;

  initial begin
    for (int k = 0; k < 9; k++) in_r[k] = '0;
    for (int k = 0; k < 3; k++) in_t[k] = '0;
  end

  always #2 clk = ~clk;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_r00(in_r[0]), .in_r01(in_r[1]), .in_r02(in_r[2]),
    .in_r10(in_r[3]), .in_r11(in_r[4]), .in_r12(in_r[5]),
    .in_r20(in_r[6]), .in_r21(in_r[7]), .in_r22(in_r[8]),
    .in_tx_in(in_t[0]), .in_ty_in(in_t[1]), .in_tz_in(in_t[2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_degenerate(out_degenerate)
  );

  // integer square root of a 64-bit value
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [17:0] clamp_q(input longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return v[17:0];
  endfunction

  // numerator * 2^23 / root, nearest, ties away from zero
  function automatic logic signed [17:0] scaled_quot(input longint d,
                                                     input longint unsigned root);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 23) + (root >> 1)) / root;
    return clamp_q((d < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic signed [17:0] half_of_root(input longint unsigned root);
    return clamp_q(longint'((root + 256) >> 9));
  endfunction

  // shepperd branch selection on trace and largest diagonal
  function automatic pose_t predict_pose(input xform_t x);
    pose_t p;
    longint m [9];
    longint trace, arg;
    longint unsigned root;
    int axis;
    for (int k = 0; k < 9; k++) m[k] = x.r[k];
    for (int k = 0; k < 3; k++) p.pos[k] = x.t[k];
    p.qx = '0; p.qy = '0; p.qz = '0; p.qw = '0; p.degen = 1'b0;
    trace = m[0] + m[4] + m[8];
    if (trace > 0) begin
      root = int_sqrt(longint'(trace + 65536) << 32);
      p.qw = half_of_root(root);
      p.qx = scaled_quot(m[7] - m[5], root);
      p.qy = scaled_quot(m[2] - m[6], root);
      p.qz = scaled_quot(m[3] - m[1], root);
    end else begin
      if (m[0] > m[4] && m[0] > m[8]) begin
        axis = 0; arg = 65536 + m[0] - m[4] - m[8];
      end else if (m[4] > m[8]) begin
        axis = 1; arg = 65536 + m[4] - m[0] - m[8];
      end else begin
        axis = 2; arg = 65536 + m[8] - m[0] - m[4];
      end
      if (arg <= 0) begin
        p.degen = 1'b1;
      end else begin
        root = int_sqrt(arg << 32);
        case (axis)
          0: begin
            p.qw = scaled_quot(m[7] - m[5], root);
            p.qx = half_of_root(root);
            p.qy = scaled_quot(m[1] + m[3], root);
            p.qz = scaled_quot(m[2] + m[6], root);
          end
          1: begin
            p.qw = scaled_quot(m[2] - m[6], root);
            p.qx = scaled_quot(m[1] + m[3], root);
            p.qy = half_of_root(root);
            p.qz = scaled_quot(m[5] + m[7], root);
          end
          default: begin
            p.qw = scaled_quot(m[3] - m[1], root);
            p.qx = scaled_quot(m[2] + m[6], root);
            p.qy = scaled_quot(m[5] + m[7], root);
            p.qz = half_of_root(root);
          end
        endcase
      end
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("error: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [17:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 18'sh1ffff;
      1: return 18'sh20000;
      2: return 18'(-65536 + $urandom_range(0, 131072));
      3: return 18'(-4096 + $urandom_range(0, 8192));
      default: return 18'($urandom);
    endcase
  endfunction

  // near-rotation matrix (signed permutation with small perturbations); one in four fully random
  function automatic xform_t rand_xform();
    xform_t x;
    int perm [3];
    int tmp, j;
    perm = '{0, 1, 2};
    for (int k = 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = perm[k]; perm[k] = perm[j]; perm[j] = tmp;
    end
    for (int k = 0; k < 9; k++) x.r[k] = 18'(int'($urandom_range(0, 4000)) - 2000);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 1)) x.r[3 * k + perm[k]] = 18'sd65536 - x.r[3 * k + perm[k]];
      else x.r[3 * k + perm[k]] = -18'sd65536 + x.r[3 * k + perm[k]];
      x.t[k] = $urandom;
    end
    if ($urandom_range(0, 3) == 0)
      for (int k = 0; k < 9; k++) x.r[k] = rand_q();
    return x;
  endfunction

  function automatic xform_t diag_xform(input int a, input int b, input int c);
    xform_t x;
    for (int k = 0; k < 9; k++) x.r[k] = '0;
    x.r[0] = 18'(a); x.r[4] = 18'(b); x.r[8] = 18'(c);
    x.r[1] = 18'sd300; x.r[3] = -18'sd700; x.r[5] = 18'sd1200; x.r[7] = 18'sd50;
    x.t[0] = 32'sh7fffffff; x.t[1] = 32'sh80000000; x.t[2] = 32'sd0;
    return x;
  endfunction

  // stimulus: directed corners then random transforms
  initial begin
    xform_t x;
    pending_xforms.push_back(diag_xform(65536, 65536, 65536));
    pending_xforms.push_back(diag_xform(65536, -65536, -65536));
    pending_xforms.push_back(diag_xform(-65536, 65536, -65536));
    pending_xforms.push_back(diag_xform(-65536, -65536, 65536));
    pending_xforms.push_back(diag_xform(0, 0, 0));
    pending_xforms.push_back(diag_xform(-100, -100, -100));
    pending_xforms.push_back(diag_xform(-100, -100, -200));
    pending_xforms.push_back(diag_xform(-131072, -131072, -131072));
    pending_xforms.push_back(diag_xform(131071, 131071, 131071));
    pending_xforms.push_back(diag_xform(131071, 131071, -131072));
    pending_xforms.push_back(diag_xform(-131072, 131071, 131071));
    pending_xforms.push_back(diag_xform(0, 1, -1));
    pending_xforms.push_back(diag_xform(-30000, -30000, -90000));
    pending_xforms.push_back(diag_xform(-65536, -65536, -65536));
    for (int k = 0; k < 4; k++) begin
      x = diag_xform(-131072, -131072, 1);
      for (int e = 0; e < 9; e++)
        if (e != 0 && e != 4 && e != 8) x.r[e] = (k[0]) ? 18'sh1ffff : 18'sh20000;
      if (k[1]) x.r[8] = 18'sd65536;
      x.t[0] = k[0] ? 32'sh80000000 : 32'sh7fffffff;
      x.t[1] = k[0] ? 32'sh7fffffff : 32'sh80000000;
      x.t[2] = k[0] ? -32'sd1 : 32'sd1;
      pending_xforms.push_back(x);
    end
    for (int k = 0; k < NumRandom; k++) pending_xforms.push_back(rand_xform());
    stimulus_done = 1'b1;
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    xform_t x;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(pending_xforms.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_xforms.size() > 0) begin
        x = pending_xforms[0];
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++) in_r[k] <= x.r[k];
        for (int k = 0; k < 3; k++) in_t[k] <= x.t[k];
        expected_poses.push_back(predict_pose(x));
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: alternating free and stalling stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_stall <= 1'b0;
    else if (stall_phase[9:8] == 2'd0) out_stall <= 1'b0;
    else if (stall_phase[9:8] == 2'd1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 9) < 6);
  end

  // monitor: compare each transaction against the oldest prediction
  always @(posedge clk) begin
    pose_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected transaction, quat_w", out_quat_w, 0);
      end else begin
        p = expected_poses.pop_front();
        if (out_pos_x !== p.pos[0]) report_mismatch("pos_x", out_pos_x, p.pos[0]);
        if (out_pos_y !== p.pos[1]) report_mismatch("pos_y", out_pos_y, p.pos[1]);
        if (out_pos_z !== p.pos[2]) report_mismatch("pos_z", out_pos_z, p.pos[2]);
        if (out_quat_x !== p.qx) report_mismatch("quat_x", out_quat_x, p.qx);
        if (out_quat_y !== p.qy) report_mismatch("quat_y", out_quat_y, p.qy);
        if (out_quat_z !== p.qz) report_mismatch("quat_z", out_quat_z, p.qz);
        if (out_quat_w !== p.qw) report_mismatch("quat_w", out_quat_w, p.qw);
        if (out_degenerate !== p.degen)
          report_mismatch("degenerate", out_degenerate, p.degen);
      end
    end
  end

  // reset, then wait for the pipeline to drain
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done);
    while (pending_xforms.size() != 0 || in_valid || expected_poses.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("rotation_matrix_to_quaternion: match");
    else $display("rotation_matrix_to_quaternion: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("rotation_matrix_to_quaternion: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
sim/rotation_matrix_to_quaternion_tb.sv
